// ----- src/gli_pkg.sv -----
// shared types, codes and helper functions for the gap linear interpolator
// no dependencies; used by the interfaces and the top level
package gli_pkg;

    localparam int TIME_W = 64;
    localparam int VAL_W  = 64;
    localparam int LIMB_W = 32;
    localparam int ACC_W  = 130;
    localparam int MAG_W  = 128;
    localparam int DCNT_W = $clog2(MAG_W);
    localparam int STEP_W = 4;
    localparam int VT_W   = 2;
    localparam int OP_W   = 2;

    localparam logic [STEP_W-1:0] SETUP_LAST = STEP_W'(2);
    localparam logic [STEP_W-1:0] MUL_LAST   = STEP_W'(8);

    typedef enum logic [OP_W-1:0] {
        OP_GROUP  = 2'd0,
        OP_FETCH  = 2'd1,
        OP_RETURN = 2'd2,
        OP_CALC   = 2'd3
    } op_t;

    typedef enum logic [VT_W-1:0] {
        VT_16 = 2'd0,
        VT_32 = 2'd1,
        VT_64 = 2'd2
    } vtype_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL,
        ST_SIGN,
        ST_DIV,
        ST_ROUND,
        ST_SAT,
        ST_EMIT
    } state_t;

    // cut a stored value to the configured width and sign-extend
    function automatic logic [VAL_W-1:0] sext_val(input logic [VAL_W-1:0] v,
                                                   input logic [VT_W-1:0] vt);
        logic [VAL_W-1:0] r;
        case (vt)
            VT_16:   r = {{(VAL_W-16){v[15]}}, v[15:0]};
            VT_32:   r = {{(VAL_W-32){v[31]}}, v[31:0]};
            default: r = v;
        endcase
        return r;
    endfunction

    // magnitude of the most negative value of the configured width
    function automatic logic [VAL_W-1:0] sat_lim(input logic [VT_W-1:0] vt);
        logic [VAL_W-1:0] r;
        case (vt)
            VT_16:   r = VAL_W'(64'h0000_0000_0000_8000);
            VT_32:   r = VAL_W'(64'h0000_0000_8000_0000);
            default: r = VAL_W'(64'h8000_0000_0000_0000);
        endcase
        return r;
    endfunction

    // most positive value of the configured width
    function automatic logic [VAL_W-1:0] sat_max(input logic [VT_W-1:0] vt);
        logic [VAL_W-1:0] r;
        case (vt)
            VT_16:   r = VAL_W'(64'h0000_0000_0000_7fff);
            VT_32:   r = VAL_W'(64'h0000_0000_7fff_ffff);
            default: r = VAL_W'(64'h7fff_ffff_ffff_ffff);
        endcase
        return r;
    endfunction

endpackage

// ----- src/gli_in_if.sv -----
// sample request channel of the gap linear interpolator
// depends on gli_pkg for field widths
interface gli_in_if;
    logic                              valid;
    logic                              ready;
    logic [gli_pkg::OP_W-1:0]          operation;
    logic signed [gli_pkg::TIME_W-1:0] sample_time;
    logic signed [gli_pkg::VAL_W-1:0]  sample_value;
    logic                              value_null;

    modport source (output valid, output operation, output sample_time,
                    output sample_value, output value_null, input ready);
    modport sink (input valid, input operation, input sample_time,
                  input sample_value, input value_null, output ready);
endinterface

// ----- src/gli_out_if.sv -----
// result channel of the gap linear interpolator
// depends on gli_pkg for field widths
interface gli_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [gli_pkg::VAL_W-1:0] result_value;
    logic                             result_null;
    logic                             divide_error;

    modport source (output valid, output result_value, output result_null,
                    output divide_error, input ready);
    modport sink (input valid, input result_value, input result_null,
                  input divide_error, output ready);
endinterface

// ----- src/gli_cfg_if.sv -----
// configuration write channel carrying the value_type register
// depends on gli_pkg for the register width
interface gli_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [gli_pkg::VT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- src/gap_linear_interpolator.sv -----
// top level of the two-point gap linear interpolator
// depends on gli_pkg, gli_in_if, gli_out_if and gli_cfg_if
//
// Keeps a previous and a next sample and answers calculate requests with
// y = (y0*(x1-x) + y1*(x-x0)) / (x1-x0), exact and rounded to nearest with ties
// away from zero, saturated to the value width set by value_type. Group change,
// row fetched and row returned requests are taken in the idle state and give no
// result. A calculate request with a missing sample or equal sample times
// goes straight from idle to the emit state. Any other calculate request
// passes through difference setup, a multiply phase with one 32x32 multiplier
// accumulating eight partial products, sign handling, a radix-2 restoring
// divider, rounding and saturation before the emit state. One request is
// worked on at a time; a finished result waits in the output register while
// the next request is accepted.
module gap_linear_interpolator (
    input  logic       clk,
    input  logic       rst_n,
    gli_in_if.sink     samples,
    gli_out_if.source  results,
    gli_cfg_if.sink    cfg
);

    localparam int TW = gli_pkg::TIME_W;
    localparam int VW = gli_pkg::VAL_W;
    localparam int LW = gli_pkg::LIMB_W;
    localparam int AW = gli_pkg::ACC_W;
    localparam int MW = gli_pkg::MAG_W;

    gli_pkg::state_t state_reg, state_next;

    logic [gli_pkg::VT_W-1:0]   value_type_reg, value_type_next;
    logic                       prev_valid_reg, prev_valid_next;
    logic                       next_valid_reg, next_valid_next;
    logic [TW-1:0]              prev_time_reg, prev_time_next;
    logic [VW-1:0]              prev_val_reg, prev_val_next;
    logic [TW-1:0]              next_time_reg, next_time_next;
    logic [VW-1:0]              next_val_reg, next_val_next;

    logic [TW-1:0]              x_reg, x_next;
    logic [VW-1:0]              y0m_reg, y0m_next, y1m_reg, y1m_next;
    logic                       y0s_reg, y0s_next, y1s_reg, y1s_next;
    logic [TW-1:0]              d1m_reg, d1m_next, d2m_reg, d2m_next;
    logic                       d1s_reg, d1s_next, d2s_reg, d2s_next;
    logic [TW-1:0]              den_m_reg, den_m_next;
    logic                       den_s_reg, den_s_next;

    logic [gli_pkg::STEP_W-1:0] step_reg, step_next;
    logic [2*LW-1:0]            pp_reg, pp_next;
    logic [1:0]                 pp_sh_reg, pp_sh_next;
    logic                       pp_neg_reg, pp_neg_next;
    logic                       pp_vld_reg, pp_vld_next;
    logic [AW-1:0]              acc_reg, acc_next;

    logic                       neg_reg, neg_next;
    logic [MW-1:0]              dvd_reg, dvd_next;
    logic [TW-1:0]              rem_reg, rem_next;
    logic [gli_pkg::DCNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [MW:0]                q_reg, q_next;

    logic [VW-1:0]              res_value_reg, res_value_next;
    logic                       res_null_reg, res_null_next;
    logic                       res_err_reg, res_err_next;

    logic                       out_valid_reg, out_valid_next;
    logic [VW-1:0]              out_value_reg, out_value_next;
    logic                       out_null_reg, out_null_next;
    logic                       out_err_reg, out_err_next;

    // shared difference unit
    logic [TW-1:0] sub_a, sub_b, sub_mag;
    logic [TW:0]   diff_ab, diff_ba;
    logic          sub_sgn;
    logic [VW-1:0] y_sel, y_ext, y_abs;

    // multiplier operands
    logic [VW-1:0] mul_a;
    logic [TW-1:0] mul_b;
    logic [LW-1:0] a_limb, b_limb;
    logic [AW-1:0] pp_ext;

    // divider step
    logic [TW:0]   r_sh;
    logic [TW+1:0] trial;
    logic          q_bit;

    logic [AW-1:0] acc_abs;
    logic [TW:0]   half_rem;
    logic [VW-1:0] lim, qm, qc;
    logic          in_take;

    assign samples.ready = (state_reg == gli_pkg::ST_IDLE);
    assign cfg.ready     = 1'b1;
    assign in_take       = samples.valid && samples.ready;

    assign results.valid        = out_valid_reg;
    assign results.result_value = out_value_reg;
    assign results.result_null  = out_null_reg;
    assign results.divide_error = out_err_reg;

    // difference operands, one per setup step
    always_comb
    begin
        case (step_reg)
            4'd0:
            begin
                sub_a = next_time_reg;
                sub_b = x_reg;
                y_sel = prev_val_reg;
            end
            4'd1:
            begin
                sub_a = x_reg;
                sub_b = prev_time_reg;
                y_sel = next_val_reg;
            end
            default:
            begin
                sub_a = next_time_reg;
                sub_b = prev_time_reg;
                y_sel = next_val_reg;
            end
        endcase
        diff_ab = {sub_a[TW-1], sub_a} - {sub_b[TW-1], sub_b};
        diff_ba = {sub_b[TW-1], sub_b} - {sub_a[TW-1], sub_a};
        sub_sgn = diff_ab[TW];
        sub_mag = sub_sgn ? diff_ba[TW-1:0] : diff_ab[TW-1:0];
        y_ext   = gli_pkg::sext_val(y_sel, value_type_reg);
        y_abs   = y_ext[VW-1] ? (~y_ext + VW'(1)) : y_ext;
    end

    // partial product selection
    always_comb
    begin
        mul_a  = step_reg[2] ? y1m_reg : y0m_reg;
        mul_b  = step_reg[2] ? d2m_reg : d1m_reg;
        a_limb = step_reg[0] ? mul_a[2*LW-1:LW] : mul_a[LW-1:0];
        b_limb = step_reg[1] ? mul_b[2*LW-1:LW] : mul_b[LW-1:0];
        case (pp_sh_reg)
            2'd0:    pp_ext = {{(AW-2*LW){1'b0}}, pp_reg};
            2'd1:    pp_ext = {{(AW-3*LW){1'b0}}, pp_reg, {LW{1'b0}}};
            2'd2:    pp_ext = {{(AW-4*LW){1'b0}}, pp_reg, {(2*LW){1'b0}}};
            default: pp_ext = '0;
        endcase
    end

    always_comb
    begin
        r_sh     = {rem_reg, dvd_reg[MW-1]};
        trial    = {1'b0, r_sh} - {2'b00, den_m_reg};
        q_bit    = !trial[TW+1];
        acc_abs  = acc_reg[AW-1] ? (~acc_reg + AW'(1)) : acc_reg;
        half_rem = {rem_reg, 1'b0};
        lim      = gli_pkg::sat_lim(value_type_reg);
        qm       = (|q_reg[MW:VW]) ? lim : q_reg[VW-1:0];
        if (neg_reg)
        begin
            qc = (qm > lim) ? lim : qm;
        end
        else
        begin
            qc = (qm > gli_pkg::sat_max(value_type_reg))
                 ? gli_pkg::sat_max(value_type_reg) : qm;
        end
    end

    // sequencer and datapath next values
    always_comb
    begin
        state_next      = state_reg;
        value_type_next = value_type_reg;
        prev_valid_next = prev_valid_reg;
        next_valid_next = next_valid_reg;
        prev_time_next  = prev_time_reg;
        prev_val_next   = prev_val_reg;
        next_time_next  = next_time_reg;
        next_val_next   = next_val_reg;
        x_next          = x_reg;
        y0m_next        = y0m_reg;
        y1m_next        = y1m_reg;
        y0s_next        = y0s_reg;
        y1s_next        = y1s_reg;
        d1m_next        = d1m_reg;
        d2m_next        = d2m_reg;
        d1s_next        = d1s_reg;
        d2s_next        = d2s_reg;
        den_m_next      = den_m_reg;
        den_s_next      = den_s_reg;
        step_next       = step_reg;
        pp_next         = pp_reg;
        pp_sh_next      = pp_sh_reg;
        pp_neg_next     = pp_neg_reg;
        pp_vld_next     = 1'b0;
        acc_next        = acc_reg;
        neg_next        = neg_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        div_cnt_next    = div_cnt_reg;
        q_next          = q_reg;
        res_value_next  = res_value_reg;
        res_null_next   = res_null_reg;
        res_err_next    = res_err_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        out_value_next  = out_value_reg;
        out_null_next   = out_null_reg;
        out_err_next    = out_err_reg;

        if (cfg.valid && cfg.ready)
        begin
            value_type_next = cfg.data;
        end

        if (pp_vld_reg)
        begin
            acc_next = pp_neg_reg ? (acc_reg - pp_ext) : (acc_reg + pp_ext);
        end

        unique case (state_reg)
            gli_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    case (samples.operation)
                        gli_pkg::OP_GROUP, gli_pkg::OP_FETCH:
                        begin
                            if (samples.operation == gli_pkg::OP_GROUP)
                            begin
                                prev_valid_next = 1'b0;
                            end
                            next_valid_next = !samples.value_null;
                            if (!samples.value_null)
                            begin
                                next_time_next = samples.sample_time;
                                next_val_next  = samples.sample_value;
                            end
                        end
                        gli_pkg::OP_RETURN:
                        begin
                            next_valid_next = 1'b0;
                            prev_valid_next = !samples.value_null;
                            if (!samples.value_null)
                            begin
                                prev_time_next = samples.sample_time;
                                prev_val_next  = samples.sample_value;
                            end
                        end
                        default:
                        begin
                            res_value_next = '0;
                            res_null_next  = 1'b0;
                            res_err_next   = 1'b0;
                            x_next         = samples.sample_time;
                            step_next      = '0;
                            if (!prev_valid_reg || !next_valid_reg)
                            begin
                                res_null_next = 1'b1;
                                state_next    = gli_pkg::ST_EMIT;
                            end
                            else if (next_time_reg == prev_time_reg)
                            begin
                                res_err_next = 1'b1;
                                state_next   = gli_pkg::ST_EMIT;
                            end
                            else
                            begin
                                state_next = gli_pkg::ST_SETUP;
                            end
                        end
                    endcase
                end
            end
            gli_pkg::ST_SETUP:
            begin
                step_next = step_reg + gli_pkg::STEP_W'(1);
                case (step_reg)
                    4'd0:
                    begin
                        d1m_next = sub_mag;
                        d1s_next = sub_sgn;
                        y0m_next = y_abs;
                        y0s_next = y_ext[VW-1];
                    end
                    4'd1:
                    begin
                        d2m_next = sub_mag;
                        d2s_next = sub_sgn;
                        y1m_next = y_abs;
                        y1s_next = y_ext[VW-1];
                    end
                    default:
                    begin
                        den_m_next = sub_mag;
                        den_s_next = sub_sgn;
                    end
                endcase
                if (step_reg == gli_pkg::SETUP_LAST)
                begin
                    step_next  = '0;
                    acc_next   = '0;
                    state_next = gli_pkg::ST_MUL;
                end
            end
            gli_pkg::ST_MUL:
            begin
                step_next = step_reg + gli_pkg::STEP_W'(1);
                if (step_reg == gli_pkg::MUL_LAST)
                begin
                    state_next = gli_pkg::ST_SIGN;
                end
                else
                begin
                    pp_vld_next = 1'b1;
                    pp_next     = a_limb * b_limb;
                    pp_sh_next  = {1'b0, step_reg[0]} + {1'b0, step_reg[1]};
                    pp_neg_next = step_reg[2] ? (y1s_reg ^ d2s_reg) : (y0s_reg ^ d1s_reg);
                end
            end
            gli_pkg::ST_SIGN:
            begin
                neg_next     = acc_reg[AW-1] ^ den_s_reg;
                dvd_next     = acc_abs[MW-1:0];
                rem_next     = '0;
                div_cnt_next = '0;
                state_next   = gli_pkg::ST_DIV;
            end
            gli_pkg::ST_DIV:
            begin
                rem_next     = q_bit ? trial[TW-1:0] : r_sh[TW-1:0];
                dvd_next     = {dvd_reg[MW-2:0], q_bit};
                div_cnt_next = div_cnt_reg + gli_pkg::DCNT_W'(1);
                if (&div_cnt_reg)
                begin
                    state_next = gli_pkg::ST_ROUND;
                end
            end
            gli_pkg::ST_ROUND:
            begin
                q_next     = {1'b0, dvd_reg} + (MW+1)'(half_rem >= {1'b0, den_m_reg});
                state_next = gli_pkg::ST_SAT;
            end
            gli_pkg::ST_SAT:
            begin
                res_value_next = neg_reg ? (~qc + VW'(1)) : qc;
                state_next     = gli_pkg::ST_EMIT;
            end
            gli_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_value_reg;
                    out_null_next  = res_null_reg;
                    out_err_next   = res_err_reg;
                    state_next     = gli_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gli_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= gli_pkg::ST_IDLE;
            value_type_reg <= gli_pkg::VT_64;
            prev_valid_reg <= 1'b0;
            next_valid_reg <= 1'b0;
            prev_time_reg  <= '0;
            prev_val_reg   <= '0;
            next_time_reg  <= '0;
            next_val_reg   <= '0;
            pp_vld_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            value_type_reg <= value_type_next;
            prev_valid_reg <= prev_valid_next;
            next_valid_reg <= next_valid_next;
            prev_time_reg  <= prev_time_next;
            prev_val_reg   <= prev_val_next;
            next_time_reg  <= next_time_next;
            next_val_reg   <= next_val_next;
            pp_vld_reg     <= pp_vld_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        y0m_reg       <= y0m_next;
        y1m_reg       <= y1m_next;
        y0s_reg       <= y0s_next;
        y1s_reg       <= y1s_next;
        d1m_reg       <= d1m_next;
        d2m_reg       <= d2m_next;
        d1s_reg       <= d1s_next;
        d2s_reg       <= d2s_next;
        den_m_reg     <= den_m_next;
        den_s_reg     <= den_s_next;
        step_reg      <= step_next;
        pp_reg        <= pp_next;
        pp_sh_reg     <= pp_sh_next;
        pp_neg_reg    <= pp_neg_next;
        acc_reg       <= acc_next;
        neg_reg       <= neg_next;
        dvd_reg       <= dvd_next;
        rem_reg       <= rem_next;
        div_cnt_reg   <= div_cnt_next;
        q_reg         <= q_next;
        res_value_reg <= res_value_next;
        res_null_reg  <= res_null_next;
        res_err_reg   <= res_err_next;
        out_value_reg <= out_value_next;
        out_null_reg  <= out_null_next;
        out_err_reg   <= out_err_next;
    end

    // remainder stays below the divisor while dividing
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == gli_pkg::ST_DIV |-> rem_reg < den_m_reg)
        else $error("divider remainder not below divisor");

    // a row request never starts a calculation
    a_row_no_calc: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && samples.operation != gli_pkg::OP_CALC |=> state_reg == gli_pkg::ST_IDLE)
        else $error("row request left the idle state");

    // null and divide error are exclusive in a delivered result
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_null_reg && out_err_reg))
        else $error("result flagged both null and divide error");

    // partial products are only in flight during the multiply phase
    a_pp_phase: assert property (@(posedge clk) disable iff (!rst_n)
        pp_vld_reg |-> state_reg == gli_pkg::ST_MUL)
        else $error("partial product outside multiply phase");

endmodule

// ----- tb/gli_interp_checker.sv -----
// checker for the gap linear interpolator: watches the request, result and config channels
// keeps its own copy of the two samples and the width code, predicts every result and compares
// depends on gli_pkg and the gli_in_if, gli_out_if and gli_cfg_if interfaces
module gli_interp_checker (
    input  logic clk,
    input  logic rst_n,
    gli_in_if    samples,
    gli_out_if   results,
    gli_cfg_if   cfg,
    output int   mismatches,
    output int   outstanding
);

    typedef struct packed {
        logic [gli_pkg::VAL_W-1:0] value;
        logic                      no_value;
        logic                      div_err;
    } interp_out_t;

    logic [gli_pkg::VT_W-1:0]   width_code;
    logic                       prev_ok;
    logic                       next_ok;
    logic [gli_pkg::TIME_W-1:0] prev_t;
    logic [gli_pkg::TIME_W-1:0] next_t;
    logic [gli_pkg::VAL_W-1:0]  prev_y;
    logic [gli_pkg::VAL_W-1:0]  next_y;
    interp_out_t                due_results [$];
    interp_out_t                want;
    interp_out_t                got;

    function automatic logic [191:0] widen(input logic [63:0] v);
        return {{128{v[63]}}, v};
    endfunction

    function automatic logic [63:0] cut_to_width(input logic [63:0] v);
        logic [63:0] r;
        case (width_code)
            gli_pkg::VT_16: r = {{48{v[15]}}, v[15:0]};
            gli_pkg::VT_32: r = {{32{v[31]}}, v[31:0]};
            default:        r = v;
        endcase
        return r;
    endfunction

    function automatic interp_out_t interpolate_at(input logic [63:0] x);
        logic [191:0] num;
        logic [191:0] den;
        logic [191:0] quo;
        logic [191:0] rem;
        logic         neg;
        logic [63:0]  mag;
        logic [63:0]  lim;
        interp_out_t  o;
        o = '0;
        if (!prev_ok || !next_ok)
        begin
            o.no_value = 1'b1;
            return o;
        end
        num = widen(cut_to_width(prev_y)) * (widen(next_t) - widen(x))
            + widen(cut_to_width(next_y)) * (widen(x) - widen(prev_t));
        den = widen(next_t) - widen(prev_t);
        if (den == '0)
        begin
            o.div_err = 1'b1;
            return o;
        end
        neg = num[191] ^ den[191];
        if (num[191])
            num = -num;
        if (den[191])
            den = -den;
        quo = num / den;
        rem = num % den;
        // round half away from zero on the magnitude
        if ({rem[190:0], 1'b0} >= den)
            quo = quo + 192'd1;
        case (width_code)
            gli_pkg::VT_16: lim = 64'h0000_0000_0000_8000;
            gli_pkg::VT_32: lim = 64'h0000_0000_8000_0000;
            default:        lim = 64'h8000_0000_0000_0000;
        endcase
        mag = (quo[191:64] != '0) ? lim : quo[63:0];
        if (neg)
            o.value = (mag > lim) ? -lim : -mag;
        else
            o.value = (mag > lim - 64'd1) ? lim - 64'd1 : mag;
        return o;
    endfunction

    task automatic check_field(input string field, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_code = gli_pkg::VT_64;
            prev_ok = 1'b0;
            next_ok = 1'b0;
            prev_t = '0;
            next_t = '0;
            prev_y = '0;
            next_y = '0;
            due_results.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                got = {results.result_value, results.result_null, results.divide_error};
                if (due_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result mismatch, expected none, actual %h %b %b", $time,
                             got.value, got.no_value, got.div_err);
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("result_value", want.value, got.value);
                    check_field("result_null", 64'(want.no_value), 64'(got.no_value));
                    check_field("divide_error", 64'(want.div_err), 64'(got.div_err));
                end
            end
            if (cfg.valid && cfg.ready)
                width_code = cfg.data;
            if (samples.valid && samples.ready)
            begin
                case (gli_pkg::op_t'(samples.operation))
                    gli_pkg::OP_GROUP, gli_pkg::OP_FETCH:
                    begin
                        if (samples.operation == gli_pkg::OP_GROUP)
                            prev_ok = 1'b0;
                        next_ok = !samples.value_null;
                        if (!samples.value_null)
                        begin
                            next_t = samples.sample_time;
                            next_y = samples.sample_value;
                        end
                    end
                    gli_pkg::OP_RETURN:
                    begin
                        next_ok = 1'b0;
                        prev_ok = !samples.value_null;
                        if (!samples.value_null)
                        begin
                            prev_t = samples.sample_time;
                            prev_y = samples.sample_value;
                        end
                    end
                    default:
                        due_results.push_back(interpolate_at(samples.sample_time));
                endcase
            end
            outstanding = due_results.size();
        end
    end

endmodule

// ----- tb/testbench.sv -----
// top of the gap linear interpolator testbench: clock, reset, stimulus, stall control, verdict
// depends on gli_pkg, the three channel interfaces, gap_linear_interpolator and gli_interp_checker
module testbench;

    localparam logic [gli_pkg::VT_W-1:0] VT_RESERVED = 2'd3;
    localparam logic [63:0] W_MAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] W_MIN = 64'h8000_0000_0000_0000;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 150;
    localparam int PHASE_ITEMS = 240;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatch_total;
    int   pending_results;
    int   snd_idle_pct = 26;
    int   rcv_idle_pct = 79;
    int   items_sent = 0;
    int   next_drain = 137;
    int   stall_cycles;

    int                       phase_snd [6] = '{26, 26, 79, 79, 0, 0};
    int                       phase_rcv [6] = '{79, 79, 26, 26, 0, 0};
    logic [gli_pkg::VT_W-1:0] phase_vt [6] = '{gli_pkg::VT_16, gli_pkg::VT_64,
                                               gli_pkg::VT_32, VT_RESERVED,
                                               gli_pkg::VT_16, gli_pkg::VT_64};

    gli_in_if  samples_ch ();
    gli_out_if results_ch ();
    gli_cfg_if cfg_ch ();

    gap_linear_interpolator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .results (results_ch),
        .cfg     (cfg_ch)
    );

    gli_interp_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (samples_ch),
        .results     (results_ch),
        .cfg         (cfg_ch),
        .mismatches  (mismatch_total),
        .outstanding (pending_results)
    );

    always #1 clk = ~clk;

    function automatic logic [63:0] small_word();
        return 64'(longint'($urandom_range(0, 2000)) - 64'sd1000);
    endfunction

    function automatic logic [63:0] pick_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: w = W_MAX;
            1: w = W_MIN;
            2: w = {{48{w[15]}}, w[15:0]};
            3: w = {{32{w[31]}}, w[31:0]};
            4: w = small_word();
            default: ;
        endcase
        return w;
    endfunction

    task automatic send_item(input gli_pkg::op_t op, input logic [63:0] t,
                             input logic [63:0] v, input logic nul);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            samples_ch.valid <= 1'b0;
            @(negedge clk);
        end
        samples_ch.valid <= 1'b1;
        samples_ch.operation <= op;
        samples_ch.sample_time <= t;
        samples_ch.sample_value <= v;
        samples_ch.value_null <= nul;
        @(posedge clk);
        while (!samples_ch.ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        samples_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_results != 0)
            @(negedge clk);
    endtask

    task automatic write_width(input logic [gli_pkg::VT_W-1:0] code);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= code;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_random(input int count);
        int          stop_at;
        int          calcs;
        logic [63:0] t0;
        logic [63:0] span;
        logic [63:0] x;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            if (items_sent >= next_drain)
            begin
                drain_results();
                next_drain = items_sent + 137;
            end
            if ($urandom_range(0, 99) < 78)
            begin
                // return then fetch gives both neighbors, then a few gap points
                if ($urandom_range(0, 3) == 0)
                    send_item(gli_pkg::OP_GROUP, pick_word(), pick_word(),
                              1'($urandom_range(0, 1)));
                t0 = ($urandom_range(0, 3) == 0) ? pick_word() : small_word();
                case ($urandom_range(0, 9))
                    0: span = '0;
                    1: span = pick_word();
                    default: span = 64'($urandom_range(1, 5000));
                endcase
                send_item(gli_pkg::OP_RETURN, t0, pick_word(), $urandom_range(0, 19) == 0);
                send_item(gli_pkg::OP_FETCH, t0 + span, pick_word(),
                          $urandom_range(0, 19) == 0);
                calcs = $urandom_range(1, 4);
                repeat (calcs)
                begin
                    if (span <= 64'd5000 && $urandom_range(0, 5) != 0)
                        x = t0 + 64'($urandom_range(0, span[31:0]));
                    else
                        x = pick_word();
                    send_item(gli_pkg::OP_CALC, x, pick_word(), 1'($urandom_range(0, 1)));
                end
            end
            else
                send_item(gli_pkg::op_t'($urandom_range(0, 3)), pick_word(), pick_word(),
                          1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        results_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            results_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((samples_ch.valid && samples_ch.ready) || (results_ch.valid && results_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        samples_ch.valid = 1'b0;
        samples_ch.operation = gli_pkg::OP_GROUP;
        samples_ch.sample_time = '0;
        samples_ch.sample_value = '0;
        samples_ch.value_null = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = gli_pkg::VT_64;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        write_width(gli_pkg::VT_64);
        @(negedge clk);

        // directed requests
        send_item(gli_pkg::OP_CALC, 64'd0, 64'd0, 1'b0);
        send_item(gli_pkg::OP_GROUP, 64'd5, 64'd100, 1'b0);
        send_item(gli_pkg::OP_CALC, 64'd5, 64'd0, 1'b0);
        send_item(gli_pkg::OP_RETURN, -64'd10, W_MIN, 1'b0);
        send_item(gli_pkg::OP_FETCH, 64'd10, W_MAX, 1'b0);
        send_item(gli_pkg::OP_CALC, 64'd0, W_MAX, 1'b1);
        send_item(gli_pkg::OP_CALC, W_MIN, 64'd0, 1'b0);
        send_item(gli_pkg::OP_CALC, W_MAX, 64'd0, 1'b0);
        send_item(gli_pkg::OP_FETCH, -64'd10, 64'd5, 1'b0);
        send_item(gli_pkg::OP_CALC, -64'd10, 64'd0, 1'b0);
        send_item(gli_pkg::OP_FETCH, 64'd99, 64'd42, 1'b1);
        send_item(gli_pkg::OP_CALC, 64'd0, 64'd0, 1'b0);
        send_item(gli_pkg::OP_FETCH, 64'd20, -64'd7, 1'b0);
        send_item(gli_pkg::OP_CALC, 64'd3, 64'd0, 1'b0);
        send_item(gli_pkg::OP_RETURN, 64'd1, 64'd1, 1'b1);
        send_item(gli_pkg::OP_CALC, 64'd3, 64'd0, 1'b0);
        send_item(gli_pkg::OP_RETURN, W_MIN, 64'd1, 1'b0);
        send_item(gli_pkg::OP_FETCH, W_MAX, -64'd1, 1'b0);
        send_item(gli_pkg::OP_CALC, 64'd0, 64'd0, 1'b0);
        send_item(gli_pkg::OP_CALC, W_MAX, 64'd0, 1'b0);
        send_item(gli_pkg::OP_GROUP, 64'd0, 64'd0, 1'b1);
        send_item(gli_pkg::OP_CALC, 64'd0, 64'd0, 1'b0);
        send_item(gli_pkg::OP_RETURN, 64'd0, 64'd3, 1'b0);
        send_item(gli_pkg::OP_FETCH, 64'd2, 64'd4, 1'b0);
        send_item(gli_pkg::OP_CALC, 64'd1, 64'd0, 1'b0);

        for (int p = 0; p < 6; p++)
        begin
            drain_results();
            repeat (SETTLE_CYCLES) @(negedge clk);
            write_width(phase_vt[p]);
            snd_idle_pct = phase_snd[p];
            rcv_idle_pct = phase_rcv[p];
            @(negedge clk);
            run_random(PHASE_ITEMS);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_total == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
